FILE: rtl/psslt_pkg.sv
// Package for the per-source sequence loss tracker.
// Holds the request and result structs, command codes, state type and constants.
// No dependencies.
package psslt_pkg;

  localparam int SRC_W     = 16;     // system id and component id bits per channel
  localparam int SEQ_W     = 8;
  localparam int CNT_W     = 32;
  localparam int TOT_W     = 33;
  localparam int Q_W       = 15;     // Q8 loss percentage
  localparam int MOD_W     = 5;      // received count modulo report period
  localparam int PROD_W    = CNT_W + Q_W;
  localparam logic [MOD_W-1:0] REPORT_LAST = 5'd30;
  localparam logic [Q_W-1:0]   FULL_SCALE  = 15'd25600;
  localparam logic [CNT_W-1:0] CNT_MAX     = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_MSG       = 2'd0;
  localparam logic [1:0] CMD_CLR_SEQ   = 2'd1;
  localparam logic [1:0] CMD_CLR_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] channel;
    logic [7:0] system_id;
    logic [7:0] component_id;
    logic [7:0] sequence_req;
    logic       is_v1;
  } in_t;

  typedef struct packed {
    logic             report_valid;
    logic [7:0]       report_system_id;
    logic [TOT_W-1:0] total_sent;
    logic [CNT_W-1:0] received_count;
    logic [CNT_W-1:0] lost_count;
    logic [Q_W-1:0]   loss_percent;
  } out_t;

  // Sequence table entry: seen flag and last sequence number
  typedef struct packed {
    logic             seen;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_UPD,
    ST_CLRS,
    ST_FIN
  } state_t;

endpackage

FILE: rtl/psslt_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module psslt_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read the old value into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/per_source_sequence_loss_tracker.sv
// Top level of the per-source sequence loss tracker.
// Depends on psslt_pkg and psslt_ram.
//
// channel | ports                       | payload
// --------+-----------------------------+---------------------
// request | in_valid, in_stall, in_data | psslt_pkg::in_t
// result  | out_valid, out_stall, out_data | psslt_pkg::out_t
//
// A counted message passes through the table read, update, multiply, 15-step divider
// for the loss percentage and result load; a repeated sequence number goes from the
// table read to the result load, and other requests go straight to the result load.
// A clear of the sequence table sweeps the channel's 65536 entries.
// After reset a clearing pass over all CHANNELS*65536 entries runs before requests are taken.
// A stalled result holds in the output register while the next request is accepted;
// the following result waits in its last state until the register frees.
module per_source_sequence_loss_tracker #(
  parameter int CHANNELS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  psslt_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output psslt_pkg::out_t  out_data
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = CH_W + psslt_pkg::SRC_W;
  localparam int DEPTH = CHANNELS * 65536;
  localparam int RAM_DEPTH = 1 << AW;
  localparam int EW    = psslt_pkg::SEQ_W + 1;

  psslt_pkg::state_t state_r, state_nxt;
  psslt_pkg::in_t    req_r;
  logic              ok_r;
  logic [CH_W-1:0]   ch_r;
  logic [AW-1:0]     cnt_r;

  logic [psslt_pkg::CNT_W-1:0] rcv_r  [CHANNELS];
  logic [psslt_pkg::CNT_W-1:0] lost_r [CHANNELS];
  logic [psslt_pkg::Q_W-1:0]   run_r  [CHANNELS];
  logic [psslt_pkg::MOD_W-1:0] mod_r  [CHANNELS];

  logic [psslt_pkg::Q_W-1:0]   num_lo_r;
  logic [psslt_pkg::TOT_W:0]   rem_r;
  logic [psslt_pkg::TOT_W-1:0] den_r;
  logic [psslt_pkg::Q_W-1:0]   q_r;
  logic [3:0]                  step_r;

  logic            out_valid_r;
  psslt_pkg::out_t out_r;

  logic              accept;
  logic              in_ok;
  logic [CH_W-1:0]   in_ch;
  logic [AW-1:0]     ram_addr;
  logic              ram_we;
  psslt_pkg::entry_t ram_wdata, ram_rdata;
  logic              fresh;
  logic              out_free;

  assign in_stall  = (state_r != psslt_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_ok     = (32'(in_data.channel) < CHANNELS);
  assign in_ch     = CH_W'(in_data.channel);
  assign fresh     = !ram_rdata.seen || (ram_rdata.seq != req_r.sequence_req);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  psslt_ram #(.WIDTH(EW), .DEPTH(RAM_DEPTH)) u_seq_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psslt_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and table access
  always_comb begin
    state_nxt = state_r;
    ram_addr  = {ch_r, req_r.system_id, req_r.component_id};
    ram_we    = 1'b0;
    ram_wdata = '{seen: 1'b1, seq: req_r.sequence_req};
    case (state_r)
      psslt_pkg::ST_INIT: begin
        ram_addr  = cnt_r;
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (cnt_r == AW'(DEPTH - 1)) state_nxt = psslt_pkg::ST_IDLE;
      end
      psslt_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_ok) state_nxt = psslt_pkg::ST_FIN;
          else if (in_data.command == psslt_pkg::CMD_CLR_SEQ) state_nxt = psslt_pkg::ST_CLRS;
          else if (in_data.command == psslt_pkg::CMD_MSG && !in_data.is_v1)
            state_nxt = psslt_pkg::ST_LOOK;
          else state_nxt = psslt_pkg::ST_FIN;
        end
      end
      psslt_pkg::ST_LOOK: state_nxt = psslt_pkg::ST_EVAL;
      psslt_pkg::ST_EVAL: begin
        if (fresh) begin
          ram_we    = 1'b1;
          state_nxt = psslt_pkg::ST_MUL;
        end else begin
          state_nxt = psslt_pkg::ST_FIN;
        end
      end
      psslt_pkg::ST_MUL: state_nxt = psslt_pkg::ST_DIV;
      psslt_pkg::ST_DIV: begin
        if (step_r == 4'd14) state_nxt = psslt_pkg::ST_UPD;
      end
      psslt_pkg::ST_UPD: state_nxt = psslt_pkg::ST_FIN;
      psslt_pkg::ST_CLRS: begin
        ram_addr  = {ch_r, cnt_r[psslt_pkg::SRC_W-1:0]};
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (cnt_r[psslt_pkg::SRC_W-1:0] == '1) state_nxt = psslt_pkg::ST_FIN;
      end
      psslt_pkg::ST_FIN: begin
        if (out_free) state_nxt = psslt_pkg::ST_IDLE;
      end
      default: state_nxt = psslt_pkg::ST_INIT;
    endcase
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (state_r == psslt_pkg::ST_INIT || state_r == psslt_pkg::ST_CLRS) begin
      cnt_r <= cnt_r + AW'(1);
    end else begin
      cnt_r <= '0;
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
      ch_r  <= in_ch;
      ok_r  <= in_ok;
    end
  end

  // channel counters
  always_ff @(posedge clk) begin
    logic [psslt_pkg::CNT_W:0]   lsum;
    logic [psslt_pkg::SEQ_W-1:0] gap;
    logic [psslt_pkg::Q_W:0]     rsum;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rcv_r[i]  <= '0;
        lost_r[i] <= '0;
        run_r[i]  <= '0;
        mod_r[i]  <= '0;
      end
    end else begin
      gap  = ram_rdata.seen ? (req_r.sequence_req - ram_rdata.seq - 8'd1) : '0;
      lsum = {1'b0, lost_r[ch_r]} + 33'(gap);
      rsum = {1'b0, q_r} + {1'b0, run_r[ch_r]};
      case (state_r)
        psslt_pkg::ST_IDLE: begin
          // clear counters of the channel
          if (accept && in_ok && in_data.command == psslt_pkg::CMD_CLR_COUNT) begin
            rcv_r[in_ch]  <= '0;
            lost_r[in_ch] <= '0;
            run_r[in_ch]  <= '0;
            mod_r[in_ch]  <= '0;
          end
        end
        psslt_pkg::ST_EVAL: begin
          // count the message, saturating
          if (rcv_r[ch_r] != psslt_pkg::CNT_MAX) begin
            rcv_r[ch_r] <= rcv_r[ch_r] + 32'd1;
            mod_r[ch_r] <= (mod_r[ch_r] == psslt_pkg::REPORT_LAST) ? '0
                           : mod_r[ch_r] + 5'd1;
          end
          if (fresh) begin
            lost_r[ch_r] <= lsum[psslt_pkg::CNT_W] ? psslt_pkg::CNT_MAX
                            : lsum[psslt_pkg::CNT_W-1:0];
          end
        end
        psslt_pkg::ST_UPD: run_r[ch_r] <= rsum[psslt_pkg::Q_W:1];
        default: ;
      endcase
    end
  end

  // loss percentage: multiply, then restoring divide one bit per cycle
  always_ff @(posedge clk) begin
    logic [psslt_pkg::PROD_W-1:0] prod;
    logic [psslt_pkg::TOT_W:0]    trial;
    logic                         ge;
    prod  = psslt_pkg::PROD_W'(lost_r[ch_r]) * psslt_pkg::PROD_W'(psslt_pkg::FULL_SCALE);
    trial = {rem_r[psslt_pkg::TOT_W-1:0], num_lo_r[psslt_pkg::Q_W-1]};
    ge    = (trial >= {1'b0, den_r});
    if (state_r == psslt_pkg::ST_MUL) begin
      den_r    <= {1'b0, rcv_r[ch_r]} + {1'b0, lost_r[ch_r]};
      rem_r    <= 34'(prod[psslt_pkg::PROD_W-1:psslt_pkg::Q_W]);
      num_lo_r <= prod[psslt_pkg::Q_W-1:0];
      step_r   <= '0;
    end else if (state_r == psslt_pkg::ST_DIV) begin
      rem_r    <= ge ? (trial - {1'b0, den_r}) : trial;
      q_r      <= {q_r[psslt_pkg::Q_W-2:0], ge};
      num_lo_r <= {num_lo_r[psslt_pkg::Q_W-2:0], 1'b0};
      step_r   <= step_r + 4'd1;
    end
  end

  // output register: load the result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == psslt_pkg::ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == psslt_pkg::ST_FIN && out_free) begin
      out_r <= '0;
      if (ok_r && req_r.command == psslt_pkg::CMD_MSG && mod_r[ch_r] == '0) begin
        out_r.report_valid     <= 1'b1;
        out_r.report_system_id <= req_r.system_id;
        out_r.total_sent       <= {1'b0, rcv_r[ch_r]} + {1'b0, lost_r[ch_r]};
        out_r.received_count   <= rcv_r[ch_r];
        out_r.lost_count       <= lost_r[ch_r];
        out_r.loss_percent     <= run_r[ch_r];
      end
    end
  end

endmodule

FILE: rtl/psslt_checker.sv
// Port-level checker for the per-source sequence loss tracker, with its bind.
// Depends on psslt_pkg and per_source_sequence_loss_tracker.
module psslt_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input psslt_pkg::out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a result without report is all zero
  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.report_valid |->
      out_data.report_system_id == 8'd0 && out_data.total_sent == 33'd0 &&
      out_data.received_count == 32'd0 && out_data.lost_count == 32'd0 &&
      out_data.loss_percent == 15'd0)
    else $error("non-report result carries data");

  // total is received plus lost
  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.report_valid |->
      out_data.total_sent == {1'b0, out_data.received_count} + {1'b0, out_data.lost_count})
    else $error("total does not match counts");

  // loss percentage stays within full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.report_valid |-> out_data.loss_percent <= psslt_pkg::FULL_SCALE)
    else $error("loss percentage out of range");

endmodule

bind per_source_sequence_loss_tracker psslt_checker u_psslt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: verif/per_source_sequence_loss_tracker_tb.sv
// Self-checking testbench for the per-source sequence loss tracker.
// Directed table followed by random source streams, checked by a predictor or typed-in results.
// Depends on psslt_pkg and the RTL top level only.
module per_source_sequence_loss_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH      = 4;
  localparam int RAND_ITEMS  = 780;
  localparam int QUIET_LIMIT = 1500000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    psslt_pkg::in_t  req;
    bit              fixed;   // expected result typed in below
    psslt_pkg::out_t res;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  psslt_pkg::in_t  in_data;
  psslt_pkg::out_t out_data;

  per_source_sequence_loss_tracker #(.CHANNELS(NUM_CH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state
  bit   [7:0]  seq_seen [int];
  bit   [7:0]  seq_last [int];
  logic [31:0] rx_cnt [NUM_CH];
  logic [31:0] lost_cnt [NUM_CH];
  logic [14:0] run_loss [NUM_CH];

  row_t stim[$];
  psslt_pkg::out_t expected_reports[$];
  int   sent, errors, quiet, checked, reports_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Advance the tracker state by one request and return its report
  function automatic psslt_pkg::out_t track_request(psslt_pkg::in_t r);
    psslt_pkg::out_t o;
    int ch, key;
    logic [7:0] gap;
    logic [63:0] total, cur;
    o = '0;
    ch = r.channel;
    if (ch >= NUM_CH) return o;
    if (r.command == psslt_pkg::CMD_CLR_SEQ) begin
      foreach (seq_seen[k]) if ((k >> 16) == ch) seq_seen[k] = 0;
      return o;
    end
    if (r.command == psslt_pkg::CMD_CLR_COUNT) begin
      rx_cnt[ch] = '0; lost_cnt[ch] = '0; run_loss[ch] = '0;
      return o;
    end
    if (r.command != psslt_pkg::CMD_MSG) return o;
    if (!r.is_v1) begin
      key = (ch << 16) | (r.system_id << 8) | r.component_id;
      rx_cnt[ch] = sat_add(rx_cnt[ch], 32'd1);
      if (!(seq_seen.exists(key) && seq_seen[key])) begin
        seq_seen[key] = 1;
        gap = 8'd0;
        seq_last[key] = r.sequence_req;
        lost_cnt[ch] = sat_add(lost_cnt[ch], 32'd0);
        total = 64'(rx_cnt[ch]) + 64'(lost_cnt[ch]);
        cur = (64'(lost_cnt[ch]) * 64'd25600) / total;
        run_loss[ch] = 15'((cur + 64'(run_loss[ch])) >> 1);
      end else if (seq_last[key] != r.sequence_req) begin
        gap = r.sequence_req - seq_last[key] - 8'd1;
        seq_last[key] = r.sequence_req;
        lost_cnt[ch] = sat_add(lost_cnt[ch], 32'(gap));
        total = 64'(rx_cnt[ch]) + 64'(lost_cnt[ch]);
        cur = (64'(lost_cnt[ch]) * 64'd25600) / total;
        run_loss[ch] = 15'((cur + 64'(run_loss[ch])) >> 1);
      end
    end
    if (rx_cnt[ch] % 31 == 0) begin
      o.report_valid     = 1'b1;
      o.report_system_id = r.system_id;
      o.total_sent       = 33'(rx_cnt[ch]) + 33'(lost_cnt[ch]);
      o.received_count   = rx_cnt[ch];
      o.lost_count       = lost_cnt[ch];
      o.loss_percent     = run_loss[ch];
    end
    return o;
  endfunction

  function automatic psslt_pkg::in_t mk(logic [1:0] cmd, logic [1:0] ch, logic [7:0] sys,
                                        logic [7:0] comp, logic [7:0] seq, logic v1);
    psslt_pkg::in_t r;
    r.command = cmd; r.channel = ch; r.system_id = sys;
    r.component_id = comp; r.sequence_req = seq; r.is_v1 = v1;
    return r;
  endfunction

  task automatic add_row(psslt_pkg::in_t r, bit fixed, psslt_pkg::out_t res);
    row_t w;
    w.req = r; w.fixed = fixed; w.res = res;
    stim.push_back(w);
  endtask

  function automatic psslt_pkg::out_t rep(logic [7:0] sys);
    psslt_pkg::out_t o;
    o = '0;
    o.report_valid = 1'b1;
    o.report_system_id = sys;
    return o;
  endfunction

  // Build the directed table and the random source streams
  task automatic build_stimulus();
    logic [7:0] src_sys [NUM_CH][3];
    logic [7:0] src_comp [NUM_CH][3];
    logic [7:0] next_seq [NUM_CH][3];
    int r, ch, s, seq_clears;
    logic [7:0] seq;
    psslt_pkg::in_t q;
    // extremes, unused command, clears, first message, repeat, wrap
    add_row(mk(psslt_pkg::CMD_MSG, 2'd0, 8'hFF, 8'h00, 8'h00, 1'b1), 1, rep(8'hFF));
    add_row(mk(CMD_UNUSED, 2'd3, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1, '0);
    add_row(mk(psslt_pkg::CMD_CLR_COUNT, 2'd3, 8'h00, 8'h00, 8'h00, 1'b0), 1, '0);
    add_row(mk(psslt_pkg::CMD_CLR_SEQ, 2'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0), 1, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0), 1, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0), 0, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd1, 8'h00, 8'h00, 8'hFF, 1'b0), 0, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0), 0, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd1, 8'hFF, 8'hFF, 8'h80, 1'b0), 0, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd1, 8'hFF, 8'hFF, 8'h7F, 1'b0), 0, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd1, 8'hAA, 8'h55, 8'h55, 1'b1), 0, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd2, 8'h55, 8'hAA, 8'hAA, 1'b1), 1, rep(8'h55));
    add_row(mk(psslt_pkg::CMD_CLR_COUNT, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0), 1, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd1, 8'h12, 8'h34, 8'h00, 1'b1), 1, rep(8'h12));
    add_row(mk(psslt_pkg::CMD_MSG, 2'd3, 8'h01, 8'h02, 8'h03, 1'b0), 0, '0);
    add_row(mk(psslt_pkg::CMD_MSG, 2'd3, 8'h01, 8'h02, 8'h13, 1'b0), 0, '0);

    foreach (src_sys[c, k]) begin
      src_sys[c][k] = $urandom_range(255);
      src_comp[c][k] = $urandom_range(255);
      next_seq[c][k] = $urandom_range(255);
    end
    seq_clears = 2;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(999);
      ch = $urandom_range(NUM_CH - 1);
      s = $urandom_range(2);
      if (r < 820) begin
        // well-formed stream with occasional gaps and repeats
        seq = next_seq[ch][s];
        r = $urandom_range(99);
        if (r < 10) seq = seq + 8'($urandom_range(1, 255));
        else if (r < 16) seq = seq - 8'd1;
        next_seq[ch][s] = seq + 8'd1;
        q = mk(psslt_pkg::CMD_MSG, 2'(ch), src_sys[ch][s], src_comp[ch][s], seq,
               ($urandom_range(99) < 5));
      end else if (r < 960) begin
        q = mk(psslt_pkg::CMD_MSG, 2'(ch), 8'($urandom), 8'($urandom), 8'($urandom),
               1'($urandom));
      end else if (r < 985) begin
        q = mk(psslt_pkg::CMD_CLR_COUNT, 2'(ch), 8'($urandom), 8'($urandom),
               8'($urandom), 1'($urandom));
      end else if (r < 997 || seq_clears == 0) begin
        q = mk(CMD_UNUSED, 2'(ch), 8'($urandom), 8'($urandom), 8'($urandom),
               1'($urandom));
      end else begin
        seq_clears--;
        q = mk(psslt_pkg::CMD_CLR_SEQ, 2'(ch), 8'($urandom), 8'($urandom),
               8'($urandom), 1'($urandom));
      end
      add_row(q, 0, '0);
    end
  endtask

  task automatic compare_report(psslt_pkg::out_t exp_r, psslt_pkg::out_t got);
    if (got !== exp_r) begin
      errors++;
      if (got.report_valid !== exp_r.report_valid)
        $display("%0t report_valid exp %0d got %0d", $time,
                 exp_r.report_valid, got.report_valid);
      if (got.report_system_id !== exp_r.report_system_id)
        $display("%0t report_system_id exp %0d got %0d", $time,
                 exp_r.report_system_id, got.report_system_id);
      if (got.total_sent !== exp_r.total_sent)
        $display("%0t total_sent exp %0d got %0d", $time,
                 exp_r.total_sent, got.total_sent);
      if (got.received_count !== exp_r.received_count)
        $display("%0t received_count exp %0d got %0d", $time,
                 exp_r.received_count, got.received_count);
      if (got.lost_count !== exp_r.lost_count)
        $display("%0t lost_count exp %0d got %0d", $time,
                 exp_r.lost_count, got.lost_count);
      if (got.loss_percent !== exp_r.loss_percent)
        $display("%0t loss_percent exp %0d got %0d", $time,
                 exp_r.loss_percent, got.loss_percent);
    end
  endtask

  // Drive requests, stall results, predict and check at each edge
  always @(posedge clk) begin
    int idle_pct, stall_pct;
    bit took;
    psslt_pkg::out_t pred;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
      in_data   <= '0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        pred = track_request(stim[sent].req);
        expected_reports.push_back(stim[sent].fixed ? stim[sent].res : pred);
        sent++;
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (out_data.report_valid === 1'b1) reports_seen++;
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t result with no request pending: %h", $time, out_data);
        end else begin
          compare_report(expected_reports.pop_front(), out_data);
        end
      end
      quiet = (took || (out_valid && !out_stall)) ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t timeout: no handshake for %0d cycles", $time, quiet);
        $display("DONE: errors detected");
        $finish;
      end
      // idle pattern: receiver then sender heavy, then none
      case (sent * 3 / stim.size())
        0: begin idle_pct = 31; stall_pct = 58; end
        1: begin idle_pct = 58; stall_pct = 31; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (!in_valid || took) begin
        if (sent < stim.size() && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= stim[sent].req;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      rx_cnt[c] = '0; lost_cnt[c] = '0; run_loss[c] = '0;
    end
    sent = 0; errors = 0; quiet = 0; checked = 0; reports_seen = 0;
    build_stimulus();
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (sent == stim.size() && expected_reports.size() == 0);
    repeat (60) @(posedge clk);
    if (expected_reports.size() != 0) begin
      errors++;
      $display("%0t %0d results never arrived", $time, expected_reports.size());
    end
    $display("Covered %0d requests, %0d results checked, %0d with a status report.",
             sent, checked, reports_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
